### rtl/plcf_pkg.sv
// plcf_pkg: shared constants, register codes and the exp2 coefficient table
// for the power-law central force pipeline. No dependencies.
package plcf_pkg;

  localparam int LOG_BITS   = 16;
  localparam int MANT_BITS  = 30;
  localparam int MW         = MANT_BITS + 1;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;
  localparam int FS_W       = 32;
  localparam int HG_W       = 16;
  localparam int HG_FRAC    = 12;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FORCE_SCALE  = 8'd0,
    REG_HALF_GAMMA   = 8'd1,
    REG_FORCE_ENABLE = 8'd2
  } cfg_reg_e;

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] x;
    r = '0;
    b = 64'd1 << 62;
    x = v;
    for (int j = 0; j < 32; j++) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // entry i is 2**(2**-i) in Q1.30, chained by repeated square roots
  function automatic logic [MW-1:0] exp2_coef(input int i);
    logic [63:0] c;
    c = isqrt64(64'd2 << (2 * MANT_BITS));
    for (int k = 1; k < LOG_BITS; k++) begin
      if (k < i) begin
        c = isqrt64(c << MANT_BITS);
      end
    end
    return c[MW-1:0];
  endfunction

endpackage

### rtl/plcf_if.sv
// plcf_if: valid/ready channel interfaces for items, results and config
// writes. Depends on plcf_pkg.
interface plcf_item_if #(parameter int PW = 32);
  logic          valid;
  logic          ready;
  logic [PW-1:0] pos_x;
  logic [PW-1:0] pos_y;
  logic [PW-1:0] pos_z;
  logic [PW-1:0] acc_x;
  logic [PW-1:0] acc_y;
  logic [PW-1:0] acc_z;
  logic          last_particle;
  modport source (output valid, pos_x, pos_y, pos_z, acc_x, acc_y, acc_z, last_particle,
                  input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, acc_x, acc_y, acc_z, last_particle,
                output ready);
endinterface

interface plcf_result_if #(parameter int PW = 32);
  logic          valid;
  logic          ready;
  logic [PW-1:0] new_acc_x;
  logic [PW-1:0] new_acc_y;
  logic [PW-1:0] new_acc_z;
  logic          skipped;
  logic          saturated;
  logic          last_out;
  modport source (output valid, new_acc_x, new_acc_y, new_acc_z, skipped, saturated,
                  last_out, input ready);
  modport sink (input valid, new_acc_x, new_acc_y, new_acc_z, skipped, saturated,
                last_out, output ready);
endinterface

interface plcf_cfg_if;
  import plcf_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/power_law_central_force_accum_core.sv
// power_law_central_force_accum_core: top level of the central force pipeline.
// Depends on plcf_pkg, plcf_if, plcf_log2 and plcf_exp2.
//
// Takes one particle item per clock and returns one result per item, in order.
// The pipeline is made of two input and square stages, 19 stages of
// the log2 unit (leading one, normalize, then one result bit per stage), two
// exponent stages, 17 stages of the exp2 unit (load, then one coefficient per
// stage), five scaling, shift and clamp stages and the output register. The whole
// pipeline advances whenever the output register is empty or taken, so the
// sustained rate is one item per cycle. Configuration writes are accepted at
// any time and should be made while no items are in flight.
module power_law_central_force_accum_core import plcf_pkg::*; #(
  parameter int POS_WIDTH = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  plcf_cfg_if.sink       cfg_i,
  plcf_item_if.sink      item_i,
  plcf_result_if.source  result_o
);

  localparam int PW  = POS_WIDTH;
  localparam int R2W = 2 * PW + 2;
  localparam int PBW = $clog2(R2W);
  localparam int LW  = PBW + 1 + LOG_BITS;
  localparam int PRW = LW + HG_W;
  localparam int EW  = LW - HG_FRAC;
  localparam int SW  = EW + 2;
  localparam int AW  = FS_W + PW;
  localparam int PPW = AW + MW;
  localparam int BLW = $clog2(PPW + 1);
  localparam int CW  = SW + BLW + 2;
  localparam int QW  = PW + 2;
  localparam int DW  = QW + 1;
  localparam int TW  = PW + 4;

  typedef struct packed {
    logic [2:0][PW-1:0] pos;
    logic [2:0][PW-1:0] acc;
    logic               last;
    logic               skip;
  } side_t;

  typedef struct packed {
    side_t                 b;
    logic signed [EW-1:0]  e_int;
  } side2_t;

  logic signed [FS_W-1:0] fs_q;
  logic signed [HG_W-1:0] hg_q;
  logic                   en_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fs_q <= '0;
      hg_q <= '0;
      en_q <= 1'b0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_FORCE_SCALE:  fs_q <= $signed(cfg_i.data[FS_W-1:0]);
        REG_HALF_GAMMA:   hg_q <= $signed(cfg_i.data[HG_W-1:0]);
        REG_FORCE_ENABLE: en_q <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  logic adv;
  logic res_v_q;
  assign adv          = !res_v_q || result_o.ready;
  assign item_i.ready = adv;

  function automatic logic [PW-1:0] mag_p(input logic [PW-1:0] v);
    return v[PW-1] ? (~v + PW'(1)) : v;
  endfunction

  // input and squares
  logic  v1_q, v2_q;
  side_t s1_q, s2_q;
  logic [2:0][2*PW-1:0] sq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (adv) begin
      v1_q <= item_i.valid;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q.pos  <= {item_i.pos_z, item_i.pos_y, item_i.pos_x};
      s1_q.acc  <= {item_i.acc_z, item_i.acc_y, item_i.acc_x};
      s1_q.last <= item_i.last_particle;
      s1_q.skip <= 1'b0;
      s2_q      <= s1_q;
      for (int k = 0; k < 3; k++) begin
        sq_q[k] <= mag_p(s1_q.pos[k]) * mag_p(s1_q.pos[k]);
      end
    end
  end

  logic [R2W-1:0] r2_w;
  side_t          s2b_w;
  always_comb begin
    r2_w = R2W'(sq_q[0]) + R2W'(sq_q[1]) + R2W'(sq_q[2]);
    s2b_w      = s2_q;
    s2b_w.skip = !en_q || (r2_w == '0);
  end

  logic                 lv_w;
  logic signed [LW-1:0] l_w;
  side_t                ls_w;

  plcf_log2 #(
    .R2W(R2W), .PBW(PBW), .LW(LW), .FRAC_BITS(FRAC_BITS), .SIDE_W($bits(side_t))
  ) u_log2 (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(v2_q), .r2_i(r2_w), .side_i(s2b_w),
    .valid_o(lv_w), .l_o(l_w), .side_o(ls_w)
  );

  // exponent
  logic                  v3_q, v4_q;
  side_t                 s3_q;
  side2_t                s4_q;
  logic signed [PRW-1:0] pr_q;
  logic [LOG_BITS-1:0]   f_q;
  logic signed [PRW:0]   ne_w;
  logic signed [PRW:0]   e_w;

  assign ne_w = -(PRW+1)'(pr_q);
  assign e_w  = ne_w >>> HG_FRAC;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (adv) begin
      v3_q <= lv_w;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pr_q       <= hg_q * l_w;
      s3_q       <= ls_w;
      s4_q.b     <= s3_q;
      s4_q.e_int <= EW'(e_w >>> LOG_BITS);
      f_q        <= e_w[LOG_BITS-1:0];
    end
  end

  logic          xv_w;
  logic [MW-1:0] m_w;
  side2_t        xs_w;

  plcf_exp2 #(.SIDE_W($bits(side2_t))) u_exp2 (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(v4_q), .f_i(f_q), .side_i(s4_q),
    .valid_o(xv_w), .m_o(m_w), .side_o(xs_w)
  );

  // scaling, shift and clamp
  logic [FS_W-1:0] fs_mag;
  assign fs_mag = fs_q[FS_W-1] ? (~fs_q + FS_W'(1)) : fs_q;

  logic                  v5_q, v6_q, v7_q, v8_q, v9_q;
  side_t                 s5_q, s6_q, s7_q, s8_q, s9_q;
  logic [MW-1:0]         m5_q;
  logic signed [EW-1:0]  e5_q, e6_q;
  logic signed [SW-1:0]  sh7_q, sh8_q;
  logic [2:0][AW-1:0]    a_q;
  logic [2:0][63:0]      plo_q;
  logic [2:0][PW+MW-1:0] phi_q;
  logic [2:0][PPW-1:0]   p7_q, p8_q;
  logic [2:0][BLW-1:0]   bl_q;
  logic [2:0]            ng5_q, ng6_q, ng7_q, ng8_q;
  logic [2:0][DW-1:0]    dl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
      v9_q <= 1'b0;
    end else if (adv) begin
      v5_q <= xv_w;
      v6_q <= v5_q;
      v7_q <= v6_q;
      v8_q <= v7_q;
      v9_q <= v8_q;
    end
  end

  logic [2:0][BLW-1:0]  bl_w;
  logic [2:0][DW-1:0]   dl_w;
  always_comb begin
    logic [QW-1:0]        q;
    logic signed [CW-1:0] lim;
    for (int k = 0; k < 3; k++) begin
      bl_w[k] = '0;
      for (int i = 0; i < PPW; i++) begin
        if (p7_q[k][i]) bl_w[k] = BLW'(i + 1);
      end
    end
    for (int k = 0; k < 3; k++) begin
      lim = CW'(sh8_q) + CW'(PW + 2);
      if (p8_q[k] == '0) begin
        q = '0;
      end else if ($signed({1'b0, CW'(bl_q[k])}) > $signed({lim[CW-1], lim})) begin
        q = QW'(1) << (PW + 1);
      end else if (sh8_q >= 0) begin
        q = QW'(p8_q[k] >> unsigned'(sh8_q));
      end else begin
        q = QW'(p8_q[k] << unsigned'(-sh8_q));
      end
      dl_w[k] = ng8_q[k] ? -DW'(q) : DW'(q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s5_q <= xs_w.b;
      m5_q <= m_w;
      e5_q <= xs_w.e_int;
      for (int k = 0; k < 3; k++) begin
        a_q[k]   <= fs_mag * mag_p(xs_w.b.pos[k]);
        ng5_q[k] <= fs_q[FS_W-1] ^ xs_w.b.pos[k][PW-1];
      end
      s6_q  <= s5_q;
      e6_q  <= e5_q;
      ng6_q <= ng5_q;
      for (int k = 0; k < 3; k++) begin
        plo_q[k] <= a_q[k][31:0] * m5_q;
        phi_q[k] <= a_q[k][AW-1:32] * m5_q;
      end
      s7_q  <= s6_q;
      ng7_q <= ng6_q;
      sh7_q <= SW'(FRAC_BITS + MANT_BITS) - SW'(e6_q);
      for (int k = 0; k < 3; k++) begin
        p7_q[k] <= PPW'(plo_q[k]) + (PPW'(phi_q[k]) << 32);
      end
      s8_q  <= s7_q;
      ng8_q <= ng7_q;
      sh8_q <= sh7_q;
      p8_q  <= p7_q;
      bl_q  <= bl_w;
      s9_q  <= s8_q;
      dl_q  <= dl_w;
    end
  end

  logic [2:0][PW-1:0] res_w;
  logic               sat_w;
  always_comb begin
    logic signed [TW-1:0] t;
    sat_w = 1'b0;
    for (int k = 0; k < 3; k++) begin
      t = TW'($signed(s9_q.acc[k])) + TW'($signed(dl_q[k]));
      if (t > $signed({{(TW-PW+1){1'b0}}, {(PW-1){1'b1}}})) begin
        res_w[k] = {1'b0, {(PW-1){1'b1}}};
        sat_w    = 1'b1;
      end else if (t < $signed({{(TW-PW+1){1'b1}}, {(PW-1){1'b0}}})) begin
        res_w[k] = {1'b1, {(PW-1){1'b0}}};
        sat_w    = 1'b1;
      end else begin
        res_w[k] = t[PW-1:0];
      end
    end
  end

  logic [2:0][PW-1:0] res_q;
  logic               skp_q, sat_q, lst_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_v_q <= 1'b0;
    end else if (adv) begin
      res_v_q <= v9_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= s9_q.skip ? s9_q.acc : res_w;
      skp_q <= s9_q.skip;
      sat_q <= !s9_q.skip && sat_w;
      lst_q <= s9_q.last;
    end
  end

  assign result_o.valid     = res_v_q;
  assign result_o.new_acc_x = res_q[0];
  assign result_o.new_acc_y = res_q[1];
  assign result_o.new_acc_z = res_q[2];
  assign result_o.skipped   = skp_q;
  assign result_o.saturated = sat_q;
  assign result_o.last_out  = lst_q;

endmodule

### rtl/plcf_log2.sv
// plcf_log2: pipelined log2 of the unsigned r squared, one result bit per
// stage, with a sideband that travels alongside. Depends on plcf_pkg.
module plcf_log2 import plcf_pkg::*; #(
  parameter int R2W       = 66,
  parameter int PBW       = 7,
  parameter int LW        = 24,
  parameter int FRAC_BITS = 16,
  parameter int SIDE_W    = 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [R2W-1:0]       r2_i,
  input  logic [SIDE_W-1:0]    side_i,
  output logic                 valid_o,
  output logic signed [LW-1:0] l_o,
  output logic [SIDE_W-1:0]    side_o
);

  logic              va_q, vb_q;
  logic [R2W-1:0]    r2a_q, r2b_q;
  logic [SIDE_W-1:0] sa_q, sb_q;
  logic [PBW-1:0]    pos_d, pb_q;

  logic              v_q    [LOG_BITS+1];
  logic [MW-1:0]     mt_q   [LOG_BITS+1];
  logic [LOG_BITS-1:0] fr_q [LOG_BITS+1];
  logic [PBW-1:0]    p_q    [LOG_BITS+1];
  logic [SIDE_W-1:0] s_q    [LOG_BITS+1];

  logic [R2W+MW-1:0] norm_w;
  logic [MW-1:0]     mt_d;

  always_comb begin
    pos_d = '0;
    for (int i = 0; i < R2W; i++) begin
      if (r2a_q[i]) pos_d = PBW'(i);
    end
  end

  always_comb begin
    if (pb_q >= PBW'(MANT_BITS)) begin
      norm_w = {{MW{1'b0}}, r2b_q} >> (pb_q - PBW'(MANT_BITS));
    end else begin
      norm_w = {{MW{1'b0}}, r2b_q} << (PBW'(MANT_BITS) - pb_q);
    end
    mt_d = norm_w[MW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q   <= 1'b0;
      vb_q   <= 1'b0;
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      va_q   <= valid_i;
      vb_q   <= va_q;
      v_q[0] <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r2a_q   <= r2_i;
      sa_q    <= side_i;
      r2b_q   <= r2a_q;
      pb_q    <= pos_d;
      sb_q    <= sa_q;
      mt_q[0] <= mt_d;
      p_q[0]  <= pb_q;
      fr_q[0] <= '0;
      s_q[0]  <= sb_q;
    end
  end

  for (genvar k = 0; k < LOG_BITS; k++) begin : g_iter
    logic [2*MW-1:0] sq_w;
    logic [MW:0]     v_w;
    assign sq_w = mt_q[k] * mt_q[k];
    assign v_w  = sq_w[MANT_BITS +: MW+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (en_i) begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        mt_q[k+1] <= v_w[MW] ? v_w[MW:1] : v_w[MW-1:0];
        fr_q[k+1] <= {fr_q[k][LOG_BITS-2:0], v_w[MW]};
        p_q[k+1]  <= p_q[k];
        s_q[k+1]  <= s_q[k];
      end
    end
  end

  logic signed [PBW:0] ip_w;
  assign ip_w    = $signed({1'b0, p_q[LOG_BITS]}) - (PBW+1)'(2 * FRAC_BITS);
  assign l_o     = {ip_w, fr_q[LOG_BITS]};
  assign valid_o = v_q[LOG_BITS];
  assign side_o  = s_q[LOG_BITS];

endmodule

### rtl/plcf_exp2.sv
// plcf_exp2: pipelined 2**f for a 16-bit fraction, one coefficient multiply
// per stage, Q1.30 result with a sideband. Depends on plcf_pkg.
module plcf_exp2 import plcf_pkg::*; #(
  parameter int SIDE_W = 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [LOG_BITS-1:0] f_i,
  input  logic [SIDE_W-1:0]   side_i,
  output logic                valid_o,
  output logic [MW-1:0]       m_o,
  output logic [SIDE_W-1:0]   side_o
);

  logic                v_q [LOG_BITS+1];
  logic [MW-1:0]       m_q [LOG_BITS+1];
  logic [LOG_BITS-1:0] f_q [LOG_BITS+1];
  logic [SIDE_W-1:0]   s_q [LOG_BITS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q[0] <= MW'(1) << MANT_BITS;
      f_q[0] <= f_i;
      s_q[0] <= side_i;
    end
  end

  for (genvar k = 0; k < LOG_BITS; k++) begin : g_step
    localparam logic [MW-1:0] Coef = exp2_coef(k + 1);
    logic [2*MW-1:0] pr_w;
    assign pr_w = m_q[k] * Coef;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (en_i) begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        m_q[k+1] <= f_q[k][LOG_BITS-1-k] ? pr_w[MANT_BITS +: MW] : m_q[k];
        f_q[k+1] <= f_q[k];
        s_q[k+1] <= s_q[k];
      end
    end
  end

  assign valid_o = v_q[LOG_BITS];
  assign m_o     = m_q[LOG_BITS];
  assign side_o  = s_q[LOG_BITS];

endmodule

### rtl/plcf_checker.sv
// plcf_checker: port-level assertions for the central force pipeline, bound
// to power_law_central_force_accum_core. Depends on the top level's ports only.
module plcf_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic skipped,
  input logic saturated
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !(skipped && saturated))
    else $error("skipped item flagged saturated");

  a_stall_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |-> !in_ready)
    else $error("item taken while pipeline stalled");

endmodule

bind power_law_central_force_accum_core plcf_checker u_plcf_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_ready  (item_i.ready),
  .out_valid (result_o.valid),
  .out_ready (result_o.ready),
  .skipped   (result_o.skipped),
  .saturated (result_o.saturated)
);
